// File: design/htc_pkg.sv
// Package for the hashed tile cache table core.
// Holds sizing constants, request kinds, state encoding and the byte hash table.
// No dependencies.
package htc_pkg;

  localparam int unsigned MaxBucketsDef = 256;
  localparam int unsigned WaysDef       = 4;
  localparam int unsigned CountW        = 9;
  localparam int unsigned TotalW        = 40;
  localparam logic [TotalW-1:0] TotalMax = {TotalW{1'b1}};
  localparam logic [CountW-1:0] CountRst = 9'd255;

  typedef enum logic [1:0] {
    KIND_LOOKUP = 2'd0,
    KIND_INSERT = 2'd1,
    KIND_REMOVE = 2'd2,
    KIND_NONE   = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HASH,
    ST_MOD,
    ST_READ,
    ST_SCAN,
    ST_DONE,
    ST_CLEAR
  } state_e;

  // Weight of each origin byte: x bytes 0..7, y bytes 0..7, z bytes 0..7.
  function automatic logic [7:0] byte_weight(input logic [4:0] idx);
    logic [7:0] w;
    case (idx)
      5'd0:  w = 8'd101;
      5'd1:  w = 8'd103;
      5'd2:  w = 8'd107;
      5'd3:  w = 8'd109;
      5'd4:  w = 8'd113;
      5'd5:  w = 8'd127;
      5'd6:  w = 8'd131;
      5'd7:  w = 8'd137;
      5'd8:  w = 8'd139;
      5'd9:  w = 8'd149;
      5'd10: w = 8'd151;
      5'd11: w = 8'd157;
      5'd12: w = 8'd163;
      5'd13: w = 8'd167;
      5'd14: w = 8'd173;
      5'd15: w = 8'd179;
      5'd16: w = 8'd181;
      5'd17: w = 8'd191;
      5'd18: w = 8'd193;
      5'd19: w = 8'd197;
      5'd20: w = 8'd199;
      5'd21: w = 8'd211;
      5'd22: w = 8'd223;
      5'd23: w = 8'd227;
      default: w = 8'd0;
    endcase
    return w;
  endfunction

endpackage

// File: design/htc_hash.sv
// Tile id hash and bucket index unit for the hashed tile cache table.
// Sums weighted origin bytes in three passes, then a restoring modulo loop.
// Depends on htc_pkg.
module htc_hash #(
  parameter int unsigned MaxBuckets = htc_pkg::MaxBucketsDef,
  parameter int unsigned BktW       = (MaxBuckets > 1) ? $clog2(MaxBuckets) : 1
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      go_i,
  input  logic [63:0]               x_i,
  input  logic [63:0]               y_i,
  input  logic [63:0]               z_i,
  input  logic [htc_pkg::CountW-1:0] count_i,
  output logic                      done_o,
  output logic [BktW-1:0]           bucket_o
);

  localparam int unsigned DivW = (BktW + 1 > htc_pkg::CountW) ? BktW + 1 : htc_pkg::CountW;
  localparam logic [DivW-1:0] MaxDiv = DivW'(MaxBuckets);

  logic [1:0]  word_q, word_d;
  logic [5:0]  bit_q, bit_d;
  logic        sum_q, sum_d, div_q, div_d;
  logic [31:0] id_q, id_d;
  logic [DivW:0] rem_q, rem_d;
  logic [DivW-1:0] dvs_q, dvs_d;
  logic [63:0] word;
  logic [31:0] part;
  logic [DivW:0] trial;

  // Word selected for the current summing pass.
  always_comb begin
    case (word_q)
      2'd0:    word = x_i;
      2'd1:    word = y_i;
      default: word = z_i;
    endcase
  end

  // Eight byte products of one word.
  always_comb begin
    part = '0;
    for (int i = 0; i < 8; i++) begin
      part = part + 32'(word[8*i +: 8]) * 32'(htc_pkg::byte_weight(5'(word_q * 8 + i)));
    end
  end

  assign trial = {rem_q[DivW-1:0], id_q[31]} - {1'b0, dvs_q};

  always_comb begin
    word_d = word_q;
    bit_d  = bit_q;
    sum_d  = sum_q;
    div_d  = div_q;
    id_d   = id_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (go_i) begin
      sum_d  = 1'b1;
      word_d = '0;
      id_d   = '0;
      // clamp the bucket count to 1..MaxBuckets
      if (count_i == '0) dvs_d = DivW'(1);
      else if (DivW'(count_i) > MaxDiv) dvs_d = MaxDiv;
      else dvs_d = DivW'(count_i);
    end else if (sum_q) begin
      id_d = id_q + part;
      if (word_q == 2'd2) begin
        sum_d = 1'b0;
        div_d = 1'b1;
        bit_d = '0;
        rem_d = '0;
      end else begin
        word_d = word_q + 2'd1;
      end
    end else if (div_q) begin
      // one quotient bit per cycle, MSB first
      if (!trial[DivW]) rem_d = {1'b0, trial[DivW-1:0]};
      else rem_d = {rem_q[DivW-1:0], id_q[31]};
      id_d = {id_q[30:0], 1'b0};
      bit_d = bit_q + 6'd1;
      if (bit_q == 6'd31) div_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q  <= 1'b0;
      div_q  <= 1'b0;
      word_q <= '0;
      bit_q  <= '0;
    end else begin
      sum_q  <= sum_d;
      div_q  <= div_d;
      word_q <= word_d;
      bit_q  <= bit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    id_q  <= id_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign done_o   = div_q && (bit_q == 6'd31) && !go_i;
  assign bucket_o = BktW'(rem_d);

endmodule

// File: design/hashed_tile_cache_table_core.sv
// Top level of the hashed tile cache table: request control, entry memory, totals.
// Depends on htc_pkg and htc_hash.
//
//  port group     | dir | handshake            | contents
//  request        | in  | start, busy          | kind, origin bits, level, handle, size
//  result         | out | done_o strobe        | found, handle, dropped, total
//  configuration  | in  | cfg_we_i             | bucket_count
//
// A request goes through hashing, the bucket modulo (one quotient bit per cycle), a read of
// each of the WAYS ways and a drain of the registered read, then the done_o strobe. busy
// drops in the cycle after the strobe, so a new request is taken only once the last is done.
// The write-back happens in the strobe cycle. After reset a clearing pass marks every entry
// invalid, one per cycle, with busy high until all MaxBuckets * WAYS entries (1024 by
// default) are cleared. Results cannot be stalled.
module hashed_tile_cache_table_core #(
  parameter int unsigned MaxBuckets = htc_pkg::MaxBucketsDef,
  parameter int unsigned Ways       = htc_pkg::WaysDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  kind_i,
  input  logic [63:0]                 x_bits_i,
  input  logic [63:0]                 y_bits_i,
  input  logic [63:0]                 z_bits_i,
  input  logic [5:0]                  res_level_i,
  input  logic [31:0]                 tile_handle_i,
  input  logic [23:0]                 tile_bytes_i,
  input  logic                        cfg_we_i,
  input  logic [htc_pkg::CountW-1:0]  cfg_wdata_i,
  output logic                        done_o,
  output logic                        found_o,
  output logic [31:0]                 handle_out_o,
  output logic                        dropped_o,
  output logic [htc_pkg::TotalW-1:0]  total_bytes_o
);

  localparam int unsigned BktW    = (MaxBuckets > 1) ? $clog2(MaxBuckets) : 1;
  localparam int unsigned WayW    = (Ways > 1) ? $clog2(Ways) : 1;
  localparam int unsigned Entries = MaxBuckets * Ways;
  localparam int unsigned AddrW   = $clog2(Entries) > 0 ? $clog2(Entries) : 1;
  localparam int unsigned WcntW   = $clog2(Ways + 1);

  typedef struct packed {
    logic        vld;
    logic [63:0] x;
    logic [63:0] y;
    logic [63:0] z;
    logic [5:0]  level;
    logic [31:0] handle;
    logic [23:0] size;
    logic [31:0] stamp;
  } entry_t;

  htc_pkg::state_e state_q, state_d;

  // request registers
  logic [1:0]  kind_q;
  logic [63:0] x_q, y_q, z_q;
  logic [5:0]  lvl_q;
  logic [31:0] hdl_q;
  logic [23:0] bytes_q;
  logic [htc_pkg::CountW-1:0] count_q;
  logic [htc_pkg::TotalW-1:0] total_q, total_d;
  logic [31:0] ictr_q, ictr_d;

  // scan state
  logic [BktW-1:0]  bkt_q, bkt_d;
  logic [WcntW-1:0] way_q, way_d;
  logic [WayW-1:0]  rway_q;
  logic             hit_q, hit_d, free_q, free_d;
  logic [WayW-1:0]  best_q, best_d, slot_q, slot_d;
  logic [31:0]      age_q, age_d, bhdl_q, bhdl_d;
  logic [23:0]      bsize_q, bsize_d;

  // clearing pass address
  logic [AddrW-1:0] clr_q;

  entry_t mem [Entries];
  entry_t rd_q, wr_data;
  logic   rd_en, wr_en, rvld_q;
  logic [AddrW-1:0] rd_addr, wr_addr;

  logic       hash_go, hash_done;
  logic [BktW-1:0] hash_bkt;
  logic       accept;

  assign accept  = start && !busy;
  assign hash_go = accept;

  htc_hash #(.MaxBuckets(MaxBuckets), .BktW(BktW)) u_hash (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .go_i     (hash_go),
    .x_i      (x_q),
    .y_i      (y_q),
    .z_i      (z_q),
    .count_i  (count_q),
    .done_o   (hash_done),
    .bucket_o (hash_bkt)
  );

  function automatic logic [AddrW-1:0] addr_of(input logic [BktW-1:0] b,
                                               input logic [WayW-1:0] w);
    logic [AddrW+WayW:0] a;
    a = (AddrW+WayW+1)'(b) * (AddrW+WayW+1)'(Ways) + (AddrW+WayW+1)'(w);
    return AddrW'(a);
  endfunction

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      htc_pkg::ST_CLEAR: if (clr_q == AddrW'(Entries - 1)) state_d = htc_pkg::ST_IDLE;
      htc_pkg::ST_IDLE: if (accept) state_d = htc_pkg::ST_HASH;
      htc_pkg::ST_HASH: if (hash_done) state_d = htc_pkg::ST_READ;
      htc_pkg::ST_READ: state_d = htc_pkg::ST_SCAN;
      htc_pkg::ST_SCAN: if (way_q == WcntW'(Ways) && !rvld_q) state_d = htc_pkg::ST_DONE;
      htc_pkg::ST_DONE: state_d = htc_pkg::ST_IDLE;
      default:          state_d = htc_pkg::ST_IDLE;
    endcase
  end

  // Memory read issue: one way per cycle in READ/SCAN.
  assign rd_en   = (state_q == htc_pkg::ST_READ || state_q == htc_pkg::ST_SCAN)
                   && way_q != WcntW'(Ways);
  assign rd_addr = addr_of(bkt_q, WayW'(way_q));

  // Scan datapath: compare returned way against the request.
  always_comb begin
    logic             v, match;
    logic [31:0]      age;
    bkt_d   = bkt_q;
    way_d   = way_q;
    hit_d   = hit_q;
    free_d  = free_q;
    best_d  = best_q;
    slot_d  = slot_q;
    age_d   = age_q;
    bhdl_d  = bhdl_q;
    bsize_d = bsize_q;
    v       = rd_q.vld;
    match   = v && rd_q.x == x_q && rd_q.y == y_q && rd_q.z == z_q && rd_q.level == lvl_q;
    age     = ictr_q - rd_q.stamp;
    if (state_q == htc_pkg::ST_HASH && hash_done) begin
      bkt_d  = hash_bkt;
      way_d  = '0;
      hit_d  = 1'b0;
      free_d = 1'b0;
    end
    if (rd_en) way_d = way_q + WcntW'(1);
    if (rvld_q) begin
      if (!v && !free_d) begin
        free_d = 1'b1;
        slot_d = rway_q;
      end
      if (match && (!hit_q || age > age_q)) begin
        hit_d   = 1'b1;
        best_d  = rway_q;
        age_d   = age;
        bhdl_d  = rd_q.handle;
        bsize_d = rd_q.size;
      end
    end
  end

  // Commit on DONE; invalidate entries during the clearing pass.
  always_comb begin
    total_d = total_q;
    ictr_d  = ictr_q;
    wr_en   = 1'b0;
    wr_addr = addr_of(bkt_q, slot_q);
    wr_data = '{vld: 1'b1, x: x_q, y: y_q, z: z_q, level: lvl_q, handle: hdl_q,
                size: bytes_q, stamp: ictr_q};
    if (state_q == htc_pkg::ST_CLEAR) begin
      wr_en       = 1'b1;
      wr_addr     = clr_q;
      wr_data.vld = 1'b0;
    end else if (state_q == htc_pkg::ST_DONE) begin
      if (kind_q == htc_pkg::KIND_INSERT && free_q) begin
        wr_en   = 1'b1;
        ictr_d  = ictr_q + 32'd1;
        total_d = ({1'b0, total_q} + (htc_pkg::TotalW+1)'(bytes_q)) > {1'b0, htc_pkg::TotalMax}
                  ? htc_pkg::TotalMax : total_q + htc_pkg::TotalW'(bytes_q);
      end else if (kind_q == htc_pkg::KIND_REMOVE && hit_q) begin
        // free the matched way
        wr_en       = 1'b1;
        wr_addr     = addr_of(bkt_q, best_q);
        wr_data.vld = 1'b0;
        total_d = (total_q >= htc_pkg::TotalW'(bsize_q)) ? total_q - htc_pkg::TotalW'(bsize_q)
                                                         : '0;
      end
    end
  end

  // Outputs.
  always_comb begin
    busy         = state_q != htc_pkg::ST_IDLE;
    done_o       = state_q == htc_pkg::ST_DONE;
    found_o      = 1'b0;
    dropped_o    = 1'b0;
    handle_out_o = '0;
    total_bytes_o = total_q;
    if (done_o) begin
      total_bytes_o = total_d;
      case (kind_q)
        htc_pkg::KIND_LOOKUP, htc_pkg::KIND_REMOVE: begin
          found_o      = hit_q;
          handle_out_o = hit_q ? bhdl_q : '0;
        end
        htc_pkg::KIND_INSERT: begin
          dropped_o    = !free_q;
          handle_out_o = free_q ? hdl_q : '0;
        end
        default: ;
      endcase
    end
  end

  // Entry memory: one read port, one write port, registered read.
  always_ff @(posedge clk_i) begin
    if (rd_en) rd_q <= mem[rd_addr];
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= htc_pkg::ST_CLEAR;
      clr_q   <= '0;
      count_q <= htc_pkg::CountRst;
      total_q <= '0;
      ictr_q  <= '0;
      rvld_q  <= 1'b0;
      way_q   <= '0;
      hit_q   <= 1'b0;
      free_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == htc_pkg::ST_CLEAR) clr_q <= clr_q + AddrW'(1);
      if (cfg_we_i) count_q <= cfg_wdata_i;
      total_q <= total_d;
      ictr_q  <= ictr_d;
      rvld_q  <= rd_en;
      way_q   <= way_d;
      hit_q   <= hit_d;
      free_q  <= free_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q  <= kind_i;
      x_q     <= x_bits_i;
      y_q     <= y_bits_i;
      z_q     <= z_bits_i;
      lvl_q   <= res_level_i;
      hdl_q   <= tile_handle_i;
      bytes_q <= tile_bytes_i;
    end
    if (rd_en) rway_q <= WayW'(way_q);
    bkt_q   <= bkt_d;
    best_q  <= best_d;
    slot_q  <= slot_d;
    age_q   <= age_d;
    bhdl_q  <= bhdl_d;
    bsize_q <= bsize_d;
  end

endmodule

// File: design/htc_checker.sv
// Port-level checks for the hashed tile cache table core, bound to the top level.
// Depends on hashed_tile_cache_table_core ports only.
module htc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic        done_o,
  input logic        found_o,
  input logic        dropped_o,
  input logic [31:0] handle_out_o
);

  // a result strobe ends the request
  a_done_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !busy) else $error("busy after result");

  // accepted request makes the block busy
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("request not taken");

  // a result comes only while busy
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy) else $error("result while idle");

  // found and dropped never together
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !(found_o && dropped_o)) else $error("found and dropped");

  // dropped result carries no handle
  a_drop_hdl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && dropped_o) |-> handle_out_o == '0) else $error("handle on drop");

endmodule

bind hashed_tile_cache_table_core htc_checker u_htc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start        (start),
  .busy         (busy),
  .done_o       (done_o),
  .found_o      (found_o),
  .dropped_o    (dropped_o),
  .handle_out_o (handle_out_o)
);

// File: tb/tb_hashed_tile_cache_table_core.sv
// Testbench for hashed_tile_cache_table_core: directed and random requests against
// a built-in predictor of the bucketed tile table. Depends on htc_pkg and the core RTL.
module tb_hashed_tile_cache_table_core;

  localparam int unsigned NBkt = htc_pkg::MaxBucketsDef;
  localparam int unsigned NWay = htc_pkg::WaysDef;
  localparam int unsigned NEnt = NBkt * NWay;

  typedef struct packed {
    htc_pkg::kind_e kind;
    logic [63:0] x;
    logic [63:0] y;
    logic [63:0] z;
    logic [5:0]  lvl;
    logic [31:0] hnd;
    logic [23:0] sz;
  } req_t;

  typedef struct packed {
    logic              found;
    logic [31:0]       hnd;
    logic              dropped;
    logic [htc_pkg::TotalW-1:0] total;
  } rsp_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [1:0] kind_i = '0;
  logic [63:0] x_bits_i = '0, y_bits_i = '0, z_bits_i = '0;
  logic [5:0] res_level_i = '0;
  logic [31:0] tile_handle_i = '0;
  logic [23:0] tile_bytes_i = '0;
  logic cfg_we_i = 1'b0;
  logic [htc_pkg::CountW-1:0] cfg_wdata_i = '0;
  logic done_o, found_o, dropped_o;
  logic [31:0] handle_out_o;
  logic [htc_pkg::TotalW-1:0] total_bytes_o;

  hashed_tile_cache_table_core u_dut (.*);

  always #10 clk_i = ~clk_i;

  // predictor state
  logic [htc_pkg::CountW-1:0] mdl_count;
  logic        mdl_vld [NEnt];
  logic [63:0] mdl_x [NEnt], mdl_y [NEnt], mdl_z [NEnt];
  logic [5:0]  mdl_lvl [NEnt];
  logic [31:0] mdl_hnd [NEnt], mdl_stamp [NEnt];
  logic [23:0] mdl_sz [NEnt];
  logic [31:0] mdl_ins_cnt;
  logic [htc_pkg::TotalW-1:0] mdl_total;

  req_t pending_reqs[$];
  rsp_t expected_rsps[$];
  int   errors = 0;
  bit   feed_done = 0;

  // recently used origins, to make hits likely
  logic [63:0] hist_x[$], hist_y[$], hist_z[$];
  logic [5:0]  hist_l[$];

  function automatic int unsigned prime_of(int i);
    int unsigned p[24] = '{101, 103, 107, 109, 113, 127, 131, 137, 139, 149, 151, 157,
                           163, 167, 173, 179, 181, 191, 193, 197, 199, 211, 223, 227};
    return p[i];
  endfunction

  function automatic int unsigned bucket_index(logic [63:0] x, logic [63:0] y,
                                               logic [63:0] z);
    logic [31:0] id;
    int unsigned n;
    logic [191:0] all;
    id = 0;
    all = {z, y, x};
    for (int i = 0; i < 24; i++) id += 32'(all[8*i +: 8]) * 32'(prime_of(i));
    n = mdl_count;
    if (n < 1) n = 1;
    if (n > NBkt) n = NBkt;
    return id % n;
  endfunction

  // compute the word the block should return and update the table
  function automatic rsp_t predict_table(req_t r);
    rsp_t o;
    int unsigned base;
    int best, slot;
    logic [31:0] best_age, age;
    logic [htc_pkg::TotalW:0] sum;
    o = '0;
    base = bucket_index(r.x, r.y, r.z) * NWay;
    if (r.kind == htc_pkg::KIND_LOOKUP || r.kind == htc_pkg::KIND_REMOVE) begin
      best = -1;
      best_age = 0;
      for (int w = 0; w < NWay; w++) begin
        int e;
        e = base + w;
        if (mdl_vld[e] && mdl_x[e] == r.x && mdl_y[e] == r.y && mdl_z[e] == r.z &&
            mdl_lvl[e] == r.lvl) begin
          age = mdl_ins_cnt - mdl_stamp[e];
          if (best < 0 || age > best_age) begin
            best = e;
            best_age = age;
          end
        end
      end
      if (best >= 0) begin
        o.found = 1'b1;
        o.hnd = mdl_hnd[best];
        if (r.kind == htc_pkg::KIND_REMOVE) begin
          mdl_vld[best] = 1'b0;
          mdl_total = (mdl_total >= mdl_sz[best]) ? mdl_total - mdl_sz[best] : '0;
        end
      end
    end else if (r.kind == htc_pkg::KIND_INSERT) begin
      slot = -1;
      for (int w = 0; w < NWay; w++)
        if (slot < 0 && !mdl_vld[base + w]) slot = base + w;
      if (slot < 0) begin
        o.dropped = 1'b1;
      end else begin
        mdl_vld[slot] = 1'b1;
        mdl_x[slot] = r.x;
        mdl_y[slot] = r.y;
        mdl_z[slot] = r.z;
        mdl_lvl[slot] = r.lvl;
        mdl_hnd[slot] = r.hnd;
        mdl_sz[slot] = r.sz;
        mdl_stamp[slot] = mdl_ins_cnt;
        mdl_ins_cnt++;
        sum = mdl_total + r.sz;
        mdl_total = sum[htc_pkg::TotalW] ? htc_pkg::TotalMax : sum[htc_pkg::TotalW-1:0];
        o.hnd = r.hnd;
      end
    end
    o.total = mdl_total;
    return o;
  endfunction

  // driver: bursts of back-to-back requests with random gaps
  int burst_left = 0, gap_left = 0;
  always @(posedge clk_i) begin
    req_t r;
    if (start && !busy) begin
      void'(pending_reqs.pop_front());
    end
    if (!rst_ni) begin
      start <= 1'b0;
    end else if (start && busy) begin
      // hold the word until it is taken
    end else if (pending_reqs.size() == 0) begin
      start <= 1'b0;
    end else if (burst_left == 0 && gap_left > 0) begin
      start <= 1'b0;
      gap_left <= gap_left - 1;
    end else begin
      r = pending_reqs[0];
      start <= 1'b1;
      kind_i <= r.kind;
      x_bits_i <= r.x;
      y_bits_i <= r.y;
      z_bits_i <= r.z;
      res_level_i <= r.lvl;
      tile_handle_i <= r.hnd;
      tile_bytes_i <= r.sz;
      if (burst_left == 0) begin
        burst_left <= $urandom_range(12, 1);
        gap_left <= ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(60, 0);
      end else begin
        burst_left <= burst_left - 1;
      end
    end
  end

  // monitor: predict from the accepted word on the ports, check each result
  always @(posedge clk_i) begin
    req_t a;
    rsp_t e;
    if (start && !busy && rst_ni) begin
      a = '{htc_pkg::kind_e'(kind_i), x_bits_i, y_bits_i, z_bits_i, res_level_i,
            tile_handle_i, tile_bytes_i};
      expected_rsps.push_back(predict_table(a));
    end
    if (done_o) begin
      if (expected_rsps.size() == 0) begin
        $display("%0t: unexpected result word found=%0b handle=%h dropped=%0b total=%h",
                 $time, found_o, handle_out_o, dropped_o, total_bytes_o);
        errors++;
      end else begin
        e = expected_rsps.pop_front();
        if (found_o !== e.found) begin
          $display("%0t: found exp %0b got %0b", $time, e.found, found_o);
          errors++;
        end
        if (handle_out_o !== e.hnd) begin
          $display("%0t: handle exp %h got %h", $time, e.hnd, handle_out_o);
          errors++;
        end
        if (dropped_o !== e.dropped) begin
          $display("%0t: dropped exp %0b got %0b", $time, e.dropped, dropped_o);
          errors++;
        end
        if (total_bytes_o !== e.total) begin
          $display("%0t: total exp %h got %h", $time, e.total, total_bytes_o);
          errors++;
        end
      end
    end
  end

  function automatic logic [63:0] pick_word();
    case ($urandom_range(5, 0))
      0: return '0;
      1: return '1;
      2: return 64'h8000_0000_0000_0000;
      3: return (64'($urandom_range(7, 0)) << 52) | 64'h3FF0_0000_0000_0000;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic req_t random_req();
    req_t r;
    int k;
    k = $urandom_range(99, 0);
    r.kind = (k < 40) ? htc_pkg::KIND_INSERT : (k < 70) ? htc_pkg::KIND_LOOKUP
             : (k < 96) ? htc_pkg::KIND_REMOVE : htc_pkg::KIND_NONE;
    if (hist_x.size() != 0 && $urandom_range(3, 0) != 0) begin
      int i;
      i = $urandom_range(hist_x.size() - 1, 0);
      r.x = hist_x[i];
      r.y = hist_y[i];
      r.z = hist_z[i];
      r.lvl = hist_l[i];
      if ($urandom_range(9, 0) == 0) r.lvl = 6'($urandom);
    end else begin
      r.x = pick_word();
      r.y = pick_word();
      r.z = pick_word();
      r.lvl = 6'($urandom);
      hist_x.push_back(r.x);
      hist_y.push_back(r.y);
      hist_z.push_back(r.z);
      hist_l.push_back(r.lvl);
      if (hist_x.size() > 40) begin
        void'(hist_x.pop_front());
        void'(hist_y.pop_front());
        void'(hist_z.pop_front());
        void'(hist_l.pop_front());
      end
    end
    r.hnd = $urandom;
    r.sz = ($urandom_range(7, 0) == 0) ? 24'hFFFFFF : 24'($urandom);
    return r;
  endfunction

  // wait until the block has drained every queued word
  task automatic drain_all();
    int guard;
    guard = 0;
    while ((pending_reqs.size() != 0 || expected_rsps.size() != 0 || start) &&
           guard < 2000000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (60) @(posedge clk_i);
  endtask

  task automatic write_count(logic [htc_pkg::CountW-1:0] v);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    mdl_count = v;
  endtask

  task automatic push(htc_pkg::kind_e k, logic [63:0] x, logic [63:0] y, logic [63:0] z,
                      logic [5:0] l, logic [31:0] h, logic [23:0] s);
    req_t r;
    r = '{k, x, y, z, l, h, s};
    pending_reqs.push_back(r);
  endtask

  initial begin
    logic [htc_pkg::CountW-1:0] counts[6] = '{9'd1, 9'd256, 9'd0, 9'd511, 9'd17, 9'd255};
    mdl_count = htc_pkg::CountRst;
    mdl_ins_cnt = 0;
    mdl_total = 0;
    foreach (mdl_vld[i]) mdl_vld[i] = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // directed: one bucket, fill past full, signed zero, NaN, duplicates, kind none
    write_count(9'd1);
    push(htc_pkg::KIND_INSERT, '0, '0, '0, 6'd0, 32'hFFFF_FFFF, 24'hFFFFFF);
    push(htc_pkg::KIND_INSERT, '0, '0, '0, 6'd0, 32'h1111_1111, 24'd5);
    push(htc_pkg::KIND_LOOKUP, 64'h8000_0000_0000_0000, '0, '0, 6'd0, '0, '0);
    push(htc_pkg::KIND_INSERT, 64'h7FF8_0000_0000_0001, '1, '1, 6'd63, 32'h2222, 24'd0);
    push(htc_pkg::KIND_INSERT, '1, '1, '1, 6'd63, 32'h3333, 24'd7);
    push(htc_pkg::KIND_INSERT, '1, '1, '1, 6'd63, 32'h4444, 24'd7);
    push(htc_pkg::KIND_LOOKUP, 64'h7FF8_0000_0000_0001, '1, '1, 6'd63, '0, '0);
    push(htc_pkg::KIND_LOOKUP, '0, '0, '0, 6'd0, '0, '0);
    push(htc_pkg::KIND_REMOVE, '0, '0, '0, 6'd0, '0, '0);
    push(htc_pkg::KIND_LOOKUP, '0, '0, '0, 6'd0, '0, '0);
    push(htc_pkg::KIND_NONE, '1, '1, '1, 6'd63, 32'h5555, 24'd9);
    push(htc_pkg::KIND_REMOVE, '0, '0, '0, 6'd0, '0, '0);
    push(htc_pkg::KIND_REMOVE, '0, '0, '0, 6'd1, '0, '0);
    push(htc_pkg::KIND_INSERT, 64'h8000_0000_0000_0000, '0, '0, 6'd0, 32'h6666, 24'd1);
    push(htc_pkg::KIND_REMOVE, 64'h8000_0000_0000_0000, '0, '0, 6'd0, '0, '0);
    drain_all();
    // random phases over several bucket counts
    foreach (counts[c]) begin
      write_count(counts[c]);
      for (int i = 0; i < 225; i++) pending_reqs.push_back(random_req());
      drain_all();
    end
    feed_done = 1;
    if (errors == 0 && expected_rsps.size() == 0) begin
      $display("Regression PASS");
    end else begin
      if (expected_rsps.size() != 0)
        $display("%0t: %0d results never arrived", $time, expected_rsps.size());
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #40000000;
    $display("Regression FAIL");
    $finish;
  end
endmodule
